[sv/uvs_pkg.sv]
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 1024;
  localparam int unsigned ANGLE_BITS_DEF   = 16;

  localparam int unsigned CNT_W = 11;
  localparam int unsigned RAD_W = 16;

  localparam logic [CNT_W-1:0] SLICE_COUNT_RST   = 11'd16;
  localparam logic [CNT_W-1:0] RING_COUNT_RST    = 11'd16;
  localparam logic [RAD_W-1:0] SPHERE_RADIUS_RST = 16'd256;

  // pi in Q29, i.e. quarter turn in Q30 radians per quarter phase
  localparam logic [30:0] PI_Q29  = 31'd1686629713;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  // series terms evaluated per sin/cos unit, and its pipeline depth
  localparam int unsigned SC_TERMS = 6;
  localparam int unsigned SC_LAT   = 4 + 3 * SC_TERMS + 1;

  typedef enum logic [3:0] {
    ADDR_SLICE_COUNT   = 4'h0,
    ADDR_RING_COUNT    = 4'h4,
    ADDR_SPHERE_RADIUS = 4'h8
  } reg_addr_t;

  // term divisors of the sine and cosine taylor series
  function automatic int unsigned sin_div(input int unsigned n);
    sin_div = (2 * n) * (2 * n + 1);
  endfunction

  function automatic int unsigned cos_div(input int unsigned n);
    cos_div = (2 * n - 1) * (2 * n);
  endfunction

endpackage

[sv/uvs_div.sv]
`timescale 1ns / 1ps
module uvs_div #(
  parameter int unsigned QD = 17
) (
  input  logic                clk,
  input  logic                en,
  input  logic [10+QD:0]      num,
  input  logic [10:0]         den,
  output logic [QD-1:0]       quo
);

  // one quotient bit per stage, remainder always below den
  logic [10:0]   rem_q [1:QD];
  logic [QD-1:0] low_q [1:QD];
  logic [QD-1:0] quo_q [1:QD];

  for (genvar i = 0; i < QD; i++) begin : g_stage
    logic [10:0]   rem_cur;
    logic [QD-1:0] low_cur;
    logic [QD-1:0] quo_cur;
    logic [11:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_cur = num[10+QD:QD];
      assign low_cur = num[QD-1:0];
      assign quo_cur = '0;
    end else begin : g_next
      assign rem_cur = rem_q[i];
      assign low_cur = low_q[i];
      assign quo_cur = quo_q[i];
    end

    assign trial = {rem_cur, low_cur[QD-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= ge ? 11'(trial - {1'b0, den}) : trial[10:0];
        low_q[i+1] <= {low_cur[QD-2:0], 1'b0};
        quo_q[i+1] <= {quo_cur[QD-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QD];

endmodule

[sv/uvs_sincos.sv]
`timescale 1ns / 1ps
module uvs_sincos #(
  parameter int unsigned ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-1:0]   phase,
  output logic signed [31:0]      sn,
  output logic signed [31:0]      cs
);

  localparam int unsigned PW = ANGLE_BITS + 29;
  localparam int unsigned NT = uvs_pkg::SC_TERMS;

  logic [1:0]        q1, q2, q3;
  logic [PW-1:0]     px1;
  logic [PW-1:0]     xr;
  logic [30:0]       x2r, x3;
  logic [61:0]       xx3;
  logic [61:0]       xx_rnd;

  logic [31:0]        t_s [0:NT];
  logic [31:0]        t_c [0:NT];
  logic signed [34:0] a_s [0:NT];
  logic signed [34:0] a_c [0:NT];
  logic [31:0]        x2b [0:NT];
  logic [1:0]         qb  [0:NT];

  // quarter-turn residue to radians in Q30
  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
      px1 <= PW'(phase[ANGLE_BITS-3:0]) * PW'(uvs_pkg::PI_Q29);
    end
  end

  assign xr = px1 + (PW'(1) << (ANGLE_BITS - 3));

  always_ff @(posedge clk) begin
    if (en) begin
      q2  <= q1;
      x2r <= xr[PW-1:ANGLE_BITS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3  <= q2;
      x3  <= x2r;
      xx3 <= 62'(x2r) * 62'(x2r);
    end
  end

  assign xx_rnd = xx3 + (62'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      qb[0]  <= q3;
      x2b[0] <= xx_rnd[61:30];
      t_s[0] <= 32'(x3);
      t_c[0] <= uvs_pkg::ONE_Q30;
      a_s[0] <= 35'(x3);
      a_c[0] <= 35'(uvs_pkg::ONE_Q30);
    end
  end

  for (genvar j = 1; j <= NT; j++) begin : g_term
    localparam int unsigned KS = uvs_pkg::sin_div(j);
    localparam int unsigned KC = uvs_pkg::cos_div(j);
    localparam logic [7:0]  KS8 = 8'(KS);
    localparam logic [7:0]  KC8 = 8'(KC);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);

    logic [63:0]        ps_a, pc_a;
    logic signed [34:0] as_a, ac_a, as_b, ac_b;
    logic [31:0]        x2_a, x2_b;
    logic [1:0]         q_a, q_b;
    logic [31:0]        p_s, p_c, p_s_b, p_c_b;
    logic [63:0]        ms_b, mc_b;
    logic [31:0]        q0_s, q0_c, tn_s, tn_c;
    logic [40:0]        r_s, r_c;

    // term times x^2
    always_ff @(posedge clk) begin
      if (en) begin
        ps_a <= 64'(t_s[j-1]) * 64'(x2b[j-1]);
        pc_a <= 64'(t_c[j-1]) * 64'(x2b[j-1]);
        as_a <= a_s[j-1];
        ac_a <= a_c[j-1];
        x2_a <= x2b[j-1];
        q_a  <= qb[j-1];
      end
    end

    assign p_s = ps_a[61:30];
    assign p_c = pc_a[61:30];

    // reciprocal estimate, low by at most one
    always_ff @(posedge clk) begin
      if (en) begin
        ms_b  <= 64'(p_s) * 64'(MS);
        mc_b  <= 64'(p_c) * 64'(MC);
        p_s_b <= p_s;
        p_c_b <= p_c;
        as_b  <= as_a;
        ac_b  <= ac_a;
        x2_b  <= x2_a;
        q_b   <= q_a;
      end
    end

    assign q0_s = ms_b[63:32];
    assign q0_c = mc_b[63:32];
    assign r_s  = 41'(p_s_b) - 41'(q0_s) * 41'(KS8);
    assign r_c  = 41'(p_c_b) - 41'(q0_c) * 41'(KC8);
    assign tn_s = q0_s + 32'(r_s >= 41'(KS8));
    assign tn_c = q0_c + 32'(r_c >= 41'(KC8));

    always_ff @(posedge clk) begin
      if (en) begin
        t_s[j] <= tn_s;
        t_c[j] <= tn_c;
        x2b[j] <= x2_b;
        qb[j]  <= q_b;
        // sine series stops one term early
        if (j > NT - 1) begin
          a_s[j] <= as_b;
        end else if ((j % 2) == 1) begin
          a_s[j] <= as_b - $signed({3'b000, tn_s});
        end else begin
          a_s[j] <= as_b + $signed({3'b000, tn_s});
        end
        if ((j % 2) == 1) begin
          a_c[j] <= ac_b - $signed({3'b000, tn_c});
        end else begin
          a_c[j] <= ac_b + $signed({3'b000, tn_c});
        end
      end
    end
  end

  logic signed [31:0] s_cl, c_cl;

  always_comb begin
    if (a_s[NT] < 0) begin
      s_cl = '0;
    end else if (a_s[NT] > 35'sd1073741824) begin
      s_cl = $signed(uvs_pkg::ONE_Q30);
    end else begin
      s_cl = 32'(a_s[NT]);
    end
    if (a_c[NT] < 0) begin
      c_cl = '0;
    end else if (a_c[NT] > 35'sd1073741824) begin
      c_cl = $signed(uvs_pkg::ONE_Q30);
    end else begin
      c_cl = 32'(a_c[NT]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qb[NT])
        2'd0: begin
          sn <= s_cl;
          cs <= c_cl;
        end
        2'd1: begin
          sn <= c_cl;
          cs <= -s_cl;
        end
        2'd2: begin
          sn <= -s_cl;
          cs <= -c_cl;
        end
        default: begin
          sn <= -c_cl;
          cs <= s_cl;
        end
      endcase
    end
  end

endmodule

[sv/uv_sphere_vertex_generator.sv]
`timescale 1ns / 1ps
// the dividers produce QD = max(ANGLE_BITS, 16) + 1 quotient bits
// throughput: one vertex per cycle; the whole pipeline advances together and
// holds while a finished vertex waits at the output register
// depth is set by the bit-per-stage dividers and the sin/cos series stages
// reset (rst, synchronous) clears all valid bits and loads the register defaults
module uv_sphere_vertex_generator #(
  parameter int unsigned MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned ANGLE_BITS   = uvs_pkg::ANGLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // ring_index[10:0], slice_index[21:11]
  output logic          m_tvalid,
  input  logic          m_tready,
  // pos_x, pos_y, pos_z (17 each), normal_x, normal_y, normal_z, tangent_x,
  // tangent_z (16 each), tex_u, tex_v (17 each), zero fill
  output logic [167:0]  m_tdata,
  output logic          m_tuser,   // index_error
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned QD  = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam int unsigned NW  = 11 + QD;
  localparam int unsigned SCL = uvs_pkg::SC_LAT;
  localparam int unsigned LAT = QD + SCL + 5;
  localparam int unsigned TXD = SCL + 4;
  localparam int unsigned MaxCnt = (MAX_SEGMENTS > 2047) ? 2047 : MAX_SEGMENTS;
  localparam logic [16:0] TexOne = 17'h10000;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    rnd = v[63] ? -$signed(m) : $signed(m);
  endfunction

  // configuration
  logic [10:0] slice_count, ring_count;
  logic [15:0] sphere_radius;
  logic [10:0] s_eff, r_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count   <= uvs_pkg::SLICE_COUNT_RST;
      ring_count    <= uvs_pkg::RING_COUNT_RST;
      sphere_radius <= uvs_pkg::SPHERE_RADIUS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        uvs_pkg::ADDR_SLICE_COUNT:   slice_count   <= pwdata[10:0];
        uvs_pkg::ADDR_RING_COUNT:    ring_count    <= pwdata[10:0];
        uvs_pkg::ADDR_SPHERE_RADIUS: sphere_radius <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      uvs_pkg::ADDR_SLICE_COUNT:   prdata = 32'(slice_count);
      uvs_pkg::ADDR_RING_COUNT:    prdata = 32'(ring_count);
      uvs_pkg::ADDR_SPHERE_RADIUS: prdata = 32'(sphere_radius);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    s_eff = slice_count;
    if (slice_count == '0) begin
      s_eff = 11'd1;
    end else if (32'(slice_count) > MaxCnt) begin
      s_eff = 11'(MaxCnt);
    end
    r_eff = ring_count;
    if (ring_count == '0) begin
      r_eff = 11'd1;
    end else if (32'(ring_count) > MaxCnt) begin
      r_eff = 11'(MaxCnt);
    end
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld;
  logic           err_sr [0:LAT-1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // input stage: saturate indices
  logic [10:0] ring_in, slice_in, ring_r, slice_r;
  logic        ring_hi, slice_hi;

  assign ring_in  = s_tdata[10:0];
  assign slice_in = s_tdata[21:11];
  assign ring_hi  = ring_in > r_eff;
  assign slice_hi = slice_in > s_eff;

  always_ff @(posedge clk) begin
    if (en) begin
      ring_r    <= ring_hi ? r_eff : ring_in;
      slice_r   <= slice_hi ? s_eff : slice_in;
      err_sr[0] <= ring_hi || slice_hi;
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_err
    always_ff @(posedge clk) begin
      if (en) begin
        err_sr[k] <= err_sr[k-1];
      end
    end
  end

  // angle and texture quotients
  logic [NW-1:0] az_num, pol_num, tu_num, tv_num;
  logic [QD-1:0] az_q, pol_q, tu_q, tv_q;

  assign az_num  = (NW'(slice_r) << ANGLE_BITS) + NW'(s_eff[10:1]);
  assign pol_num = (NW'(ring_r) << (ANGLE_BITS - 1)) + NW'(r_eff[10:1]);
  assign tu_num  = (NW'(slice_r) << 16) + NW'(s_eff[10:1]);
  assign tv_num  = (NW'(ring_r) << 16) + NW'(r_eff[10:1]);

  uvs_div #(.QD(QD)) u_div_az  (.clk(clk), .en(en), .num(az_num),  .den(s_eff), .quo(az_q));
  uvs_div #(.QD(QD)) u_div_pol (.clk(clk), .en(en), .num(pol_num), .den(r_eff), .quo(pol_q));
  uvs_div #(.QD(QD)) u_div_tu  (.clk(clk), .en(en), .num(tu_num),  .den(s_eff), .quo(tu_q));
  uvs_div #(.QD(QD)) u_div_tv  (.clk(clk), .en(en), .num(tv_num),  .den(r_eff), .quo(tv_q));

  logic [16:0] tu_sr [0:TXD-1];
  logic [16:0] tv_sr [0:TXD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tu_sr[0] <= TexOne - tu_q[16:0];
      tv_sr[0] <= tv_q[16:0];
    end
  end

  for (genvar k = 1; k < TXD; k++) begin : g_tex
    always_ff @(posedge clk) begin
      if (en) begin
        tu_sr[k] <= tu_sr[k-1];
        tv_sr[k] <= tv_sr[k-1];
      end
    end
  end

  // sin/cos of azimuth and polar angle
  logic signed [31:0] sa, ca, sp, cp;

  uvs_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_az (
    .clk(clk), .en(en), .phase(az_q[ANGLE_BITS-1:0]), .sn(sa), .cs(ca)
  );
  uvs_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_pol (
    .clk(clk), .en(en), .phase(pol_q[ANGLE_BITS-1:0]), .sn(sp), .cs(cp)
  );

  // normal products
  logic signed [63:0] nxp1, nzp1;
  logic signed [31:0] sa1, ca1, cp1;

  always_ff @(posedge clk) begin
    if (en) begin
      nxp1 <= 64'(sa) * 64'(sp);
      nzp1 <= 64'(ca) * 64'(sp);
      sa1  <= sa;
      ca1  <= ca;
      cp1  <= cp;
    end
  end

  logic signed [31:0] nx2, ny2, nz2, sa2, ca2;

  always_ff @(posedge clk) begin
    if (en) begin
      nx2 <= 32'(rnd(nxp1, 30));
      ny2 <= cp1;
      nz2 <= 32'(rnd(nzp1, 30));
      sa2 <= sa1;
      ca2 <= ca1;
    end
  end

  // radius scaling, normal and tangent rounding
  logic signed [63:0] pxp3, pyp3, pzp3;
  logic signed [15:0] nx3, ny3, nz3, tx3, tz3;
  logic signed [63:0] rad_s;

  assign rad_s = $signed({48'd0, sphere_radius});

  always_ff @(posedge clk) begin
    if (en) begin
      pxp3 <= 64'(nx2) * rad_s;
      pyp3 <= 64'(ny2) * rad_s;
      pzp3 <= 64'(nz2) * rad_s;
      nx3  <= 16'(rnd(64'(nx2), 16));
      ny3  <= 16'(rnd(64'(ny2), 16));
      nz3  <= 16'(rnd(64'(nz2), 16));
      tx3  <= 16'(rnd(-64'(ca2), 16));
      tz3  <= 16'(rnd(64'(sa2), 16));
    end
  end

  // output register
  logic [16:0] px4, py4, pz4;
  logic [15:0] nx4, ny4, nz4, tx4, tz4;

  always_ff @(posedge clk) begin
    if (en) begin
      px4 <= 17'(rnd(pxp3, 30));
      py4 <= 17'(rnd(pyp3, 30));
      pz4 <= 17'(rnd(pzp3, 30));
      nx4 <= nx3;
      ny4 <= ny3;
      nz4 <= nz3;
      tx4 <= tx3;
      tz4 <= tz3;
    end
  end

  assign m_tdata = {3'b000, tv_sr[TXD-1], tu_sr[TXD-1], tz4, tx4, nz4, ny4, nx4,
                    pz4, py4, px4};
  assign m_tuser = err_sr[LAT-1];

  // a waiting vertex is never dropped by the shared enable
  property p_hold;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=> m_tvalid;
  endproperty
  a_hold: assert property (p_hold) else $error("vertex lost while stalled");

  property p_ny_range;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> ($signed(m_tdata[82:67]) <= 16'sd16384 &&
                    $signed(m_tdata[82:67]) >= -16'sd16384);
  endproperty
  a_ny_range: assert property (p_ny_range) else $error("normal_y out of unit range");

  property p_tan_range;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> ($signed(m_tdata[114:99]) <= 16'sd16384 &&
                    $signed(m_tdata[114:99]) >= -16'sd16384 &&
                    $signed(m_tdata[130:115]) <= 16'sd16384 &&
                    $signed(m_tdata[130:115]) >= -16'sd16384);
  endproperty
  a_tan_range: assert property (p_tan_range) else $error("tangent out of unit range");

  property p_tex_range;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[147:131] <= 17'h10000 && m_tdata[164:148] <= 17'h10000);
  endproperty
  a_tex_range: assert property (p_tex_range) else $error("texture coordinate above one");

endmodule
